// ----- hdl/line_pixel_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication
`define LPG_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator package
// Widths, register indexes, octant codes and sequencer states.
// ----------------------------------------------------------------------------
package lpg_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int LENGTH_WIDTH   = 14;
	localparam int SLOPE_WIDTH    = 16;
	localparam int PROD_WIDTH     = SLOPE_WIDTH + LENGTH_WIDTH;
	localparam int QSUM_WIDTH     = ((PROD_WIDTH > COORD_WIDTH) ? PROD_WIDTH : COORD_WIDTH) + 1;
	localparam int CFG_DATA_WIDTH = (COORD_WIDTH > SLOPE_WIDTH) ? COORD_WIDTH : SLOPE_WIDTH;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int IN_DATA_WIDTH  = 8;
	localparam int OUT_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
	localparam int MUL_CNT_WIDTH  = $clog2(LENGTH_WIDTH + 1);
	localparam int DIV_CNT_WIDTH  = $clog2(PROD_WIDTH + 1);

	typedef logic [COORD_WIDTH-1:0]  coord_t;
	typedef logic [LENGTH_WIDTH-1:0] length_t;
	typedef logic [SLOPE_WIDTH-1:0]  slope_t;
	typedef logic [PROD_WIDTH-1:0]   prod_t;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_X     = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_Y     = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OCTANT      = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINE_LENGTH = CFG_INDEX_WIDTH'(3);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOPE_TERM  = CFG_INDEX_WIDTH'(4);

	// octant codes: major axis and direction, then minor offset sign
	localparam logic [2:0] OCT_YPOS_XADD = 3'd0;
	localparam logic [2:0] OCT_XPOS_YADD = 3'd1;
	localparam logic [2:0] OCT_XPOS_YSUB = 3'd2;
	localparam logic [2:0] OCT_YNEG_XADD = 3'd3;
	localparam logic [2:0] OCT_YNEG_XSUB = 3'd4;
	localparam logic [2:0] OCT_XNEG_YSUB = 3'd5;
	localparam logic [2:0] OCT_XNEG_YADD = 3'd6;
	localparam logic [2:0] OCT_YPOS_XSUB = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ----- hdl/lpg_serial_mul.sv -----
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add over the multiplier bits, most significant first, one per cycle.
// ----------------------------------------------------------------------------
module lpg_serial_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lpg_pkg::slope_t  multiplicand,
	input  lpg_pkg::length_t multiplier,
	output logic            done,
	output lpg_pkg::prod_t   product
);

	logic [lpg_pkg::MUL_CNT_WIDTH-1:0] cnt_q;
	logic                              busy_q;
	logic                              done_q;
	lpg_pkg::prod_t                    acc_q;
	lpg_pkg::length_t                  mplier_q;
	lpg_pkg::slope_t                   mcand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lpg_pkg::MUL_CNT_WIDTH'(lpg_pkg::LENGTH_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - lpg_pkg::MUL_CNT_WIDTH'(1);
				if (cnt_q == lpg_pkg::MUL_CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mplier_q <= multiplier;
			mcand_q  <= multiplicand;
		end else if (busy_q) begin
			acc_q <= (acc_q << 1)
				+ (mplier_q[lpg_pkg::LENGTH_WIDTH-1] ? lpg_pkg::PROD_WIDTH'(mcand_q) : '0);
			mplier_q <= mplier_q << 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- hdl/lpg_serial_div.sv -----
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle; quotient bits shift into the dividend register.
// ----------------------------------------------------------------------------
module lpg_serial_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lpg_pkg::prod_t   dividend,
	input  lpg_pkg::length_t divisor,
	output logic            done,
	output lpg_pkg::prod_t   quotient
);

	logic [lpg_pkg::DIV_CNT_WIDTH-1:0] cnt_q;
	logic                              busy_q;
	logic                              done_q;
	lpg_pkg::prod_t                    dvd_q;
	lpg_pkg::length_t                  rem_q;
	lpg_pkg::length_t                  dsr_q;
	logic [lpg_pkg::LENGTH_WIDTH:0]    shifted;
	logic [lpg_pkg::LENGTH_WIDTH:0]    diff;
	logic                              fits;

	always_comb begin
		shifted = {rem_q, dvd_q[lpg_pkg::PROD_WIDTH-1]};
		diff    = shifted - {1'b0, dsr_q};
		fits    = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lpg_pkg::DIV_CNT_WIDTH'(lpg_pkg::PROD_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - lpg_pkg::DIV_CNT_WIDTH'(1);
				if (cnt_q == lpg_pkg::DIV_CNT_WIDTH'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the low bits
			rem_q <= fits ? diff[lpg_pkg::LENGTH_WIDTH-1:0]
				: shifted[lpg_pkg::LENGTH_WIDTH-1:0];
			dvd_q <= {dvd_q[lpg_pkg::PROD_WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- hdl/line_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator
// Emits one pixel coordinate per input transfer along a configured line.
// ----------------------------------------------------------------------------
// Sequence from input transfer to result valid: set-up, bit-serial multiply,
//   hand-off to the divider, radix-2 divide, coordinate add into the output
//   register; a zero-length line skips the multiply and divide.
// Flow: a new input is taken only while the sequencer is idle, so one item is
//   in flight at a time; a full output register holds the sequencer.
// Reset: arst_n clears registers, step index, running flag and output valid.
module line_pixel_generator (
	input  logic clk,
	input  logic arst_n,

	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lpg_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [lpg_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,

	// input ticks
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [lpg_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,  // [0] restart, rest unused

	// pixel results
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [lpg_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,  // pixel_x in the low half, pixel_y in the high half
	output logic                                  m_axis_tlast   // last pixel of the line
);

`include "line_pixel_generator_defines.svh"

	// configuration registers
	lpg_pkg::coord_t  start_x_q;
	lpg_pkg::coord_t  start_y_q;
	logic [2:0]       octant_q;
	lpg_pkg::length_t line_length_q;
	lpg_pkg::slope_t  slope_term_q;

	// line walk state
	lpg_pkg::length_t step_q;
	logic             running_q;

	// per-item working registers
	lpg_pkg::state_t  state_q, state_d;
	lpg_pkg::length_t i_q;
	logic             last_q;
	lpg_pkg::coord_t  s_q;

	// output register
	logic             out_valid_q;
	lpg_pkg::coord_t  out_x_q;
	lpg_pkg::coord_t  out_y_q;
	logic             out_last_q;

	logic             in_xfer;
	logic             cfg_xfer;
	logic             out_load;
	logic             restart;
	lpg_pkg::length_t i_next;
	logic             len_zero;
	logic             mul_start;
	logic             mul_done;
	lpg_pkg::prod_t   product;
	logic             div_done;
	lpg_pkg::prod_t   quotient;
	logic [lpg_pkg::QSUM_WIDTH-1:0] qsum;
	lpg_pkg::coord_t  major;
	lpg_pkg::coord_t  pix_x;
	lpg_pkg::coord_t  pix_y;

	assign cfg_ready     = 1'b1;
	assign cfg_xfer      = cfg_valid & cfg_ready;
	assign s_axis_tready = (state_q == lpg_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign restart       = s_axis_tdata[0];
	assign len_zero      = (line_length_q == '0);
	assign mul_start     = in_xfer & ~len_zero;

	// an idle tick starts the line over just like restart
	assign i_next = (restart || !running_q) ? '0 : step_q;

	// minor offset: round the quotient by adding one and halving
	assign qsum = lpg_pkg::QSUM_WIDTH'(quotient) + lpg_pkg::QSUM_WIDTH'(1);

	lpg_serial_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (slope_term_q),
		.multiplier   (i_next),
		.done         (mul_done),
		.product      (product)
	);

	lpg_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_done),
		.dividend (product),
		.divisor  (line_length_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// sequencer: multiply, divide, then wait for room in the output register
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			lpg_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = len_zero ? lpg_pkg::ST_OUT : lpg_pkg::ST_MUL;
				end
			end
			lpg_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d = lpg_pkg::ST_DIV;
				end
			end
			lpg_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = lpg_pkg::ST_OUT;
				end
			end
			lpg_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = lpg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpg_pkg::ST_IDLE;
			end
		endcase
	end

	// coordinates: major axis moves by i, minor by the offset
	always_comb begin
		major = lpg_pkg::COORD_WIDTH'(i_q);
		case (octant_q)
			lpg_pkg::OCT_YPOS_XADD: begin pix_x = start_x_q + s_q;   pix_y = start_y_q + major; end
			lpg_pkg::OCT_XPOS_YADD: begin pix_x = start_x_q + major; pix_y = start_y_q + s_q;   end
			lpg_pkg::OCT_XPOS_YSUB: begin pix_x = start_x_q + major; pix_y = start_y_q - s_q;   end
			lpg_pkg::OCT_YNEG_XADD: begin pix_x = start_x_q + s_q;   pix_y = start_y_q - major; end
			lpg_pkg::OCT_YNEG_XSUB: begin pix_x = start_x_q - s_q;   pix_y = start_y_q - major; end
			lpg_pkg::OCT_XNEG_YSUB: begin pix_x = start_x_q - major; pix_y = start_y_q - s_q;   end
			lpg_pkg::OCT_XNEG_YADD: begin pix_x = start_x_q - major; pix_y = start_y_q + s_q;   end
			default:                begin pix_x = start_x_q - s_q;   pix_y = start_y_q + major; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and line walk; a write to any defined register stops the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '0;
			start_y_q     <= '0;
			octant_q      <= '0;
			line_length_q <= '0;
			slope_term_q  <= '0;
			step_q        <= '0;
			running_q     <= 1'b0;
		end else if (cfg_xfer) begin
			case (cfg_index)
				lpg_pkg::REG_START_X: begin
					start_x_q <= cfg_data[lpg_pkg::COORD_WIDTH-1:0];
					running_q <= 1'b0;
				end
				lpg_pkg::REG_START_Y: begin
					start_y_q <= cfg_data[lpg_pkg::COORD_WIDTH-1:0];
					running_q <= 1'b0;
				end
				lpg_pkg::REG_OCTANT: begin
					octant_q  <= cfg_data[2:0];
					running_q <= 1'b0;
				end
				lpg_pkg::REG_LINE_LENGTH: begin
					line_length_q <= cfg_data[lpg_pkg::LENGTH_WIDTH-1:0];
					running_q     <= 1'b0;
				end
				lpg_pkg::REG_SLOPE_TERM: begin
					slope_term_q <= cfg_data[lpg_pkg::SLOPE_WIDTH-1:0];
					running_q    <= 1'b0;
				end
				default: begin
					// unknown index: ignored
				end
			endcase
		end else if (in_xfer) begin
			if (i_next >= line_length_q) begin
				running_q <= 1'b0;
				step_q    <= '0;
			end else begin
				running_q <= 1'b1;
				step_q    <= i_next + lpg_pkg::LENGTH_WIDTH'(1);
			end
		end
	end

	// per-item payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			i_q    <= i_next;
			last_q <= (i_next >= line_length_q);
			if (len_zero) begin
				s_q <= '0;
			end
		end
		if (div_done) begin
			s_q <= lpg_pkg::COORD_WIDTH'(qsum >> 1);
		end
	end

	// output register frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q    <= pix_x;
			out_y_q    <= pix_y;
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = lpg_pkg::OUT_DATA_WIDTH'({out_y_q, out_x_q});

	`LPG_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready,
		"input accepted while an item is in flight")
	`LPG_ASSERT_NEXT(a_zero_len_direct, in_xfer && len_zero, state_q == lpg_pkg::ST_OUT,
		"zero length line did not skip the arithmetic")
	`LPG_ASSERT_IMPLY(a_mul_done_state, mul_done, state_q == lpg_pkg::ST_MUL,
		"multiplier finished outside the multiply phase")
	`LPG_ASSERT_IMPLY(a_div_done_state, div_done, state_q == lpg_pkg::ST_DIV,
		"divider finished outside the divide phase")

endmodule
